@@ hw/rtl/itrad_pkg.sv @@
// Shared types, constants and microcode for the integer to ASCII digit converter.
package itrad_pkg;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned NumDigits  = 11;
  localparam int unsigned DigitW     = 4;
  localparam int unsigned DigW       = NumDigits * DigitW;
  localparam int unsigned OctW       = 3 * NumDigits;
  localparam int unsigned CntW       = $clog2(ValueWidth + 1);
  localparam int unsigned IdxW       = $clog2(NumDigits);
  localparam int unsigned UpcW       = 3;
  localparam int unsigned CharW      = 7;

  typedef enum logic [1:0] {
    OP_DEC = 2'd0,
    OP_OCT = 2'd1,
    OP_HEX = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ACT_NOP    = 3'd0,
    ACT_LOAD   = 3'd1,
    ACT_DABBLE = 3'd2,
    ACT_SHIFT  = 3'd3,
    ACT_EMIT   = 3'd4
  } act_e;

  typedef enum logic [2:0] {
    COND_ALWAYS     = 3'd0,
    COND_NO_IN      = 3'd1,
    COND_CNT_NZ     = 3'd2,
    COND_LEAD_ZERO  = 3'd3,
    COND_EMIT_AGAIN = 3'd4
  } cond_e;

  typedef struct packed {
    act_e             act;
    cond_e            cond;
    logic [UpcW-1:0]  target;
  } uword_t;

  typedef struct packed {
    logic in_valid;
    logic cnt_nz;
    logic lead_zero;
    logic out_busy;
    logic idx_nz;
  } dp_status_t;

  localparam logic [UpcW-1:0] UPC_WAIT = 3'd0;
  localparam logic [UpcW-1:0] UPC_CONV = 3'd1;
  localparam logic [UpcW-1:0] UPC_SKIP = 3'd2;
  localparam logic [UpcW-1:0] UPC_EMIT = 3'd3;
  localparam logic [UpcW-1:0] UPC_DONE = 3'd4;

  localparam logic [CharW-1:0] CharZero   = 7'h30;
  localparam logic [CharW-1:0] CharLetter = 7'h57; // 'a' - 10

  // Jump to target when cond holds, else fall through to the next step.
  function automatic uword_t ucode_rom(logic [UpcW-1:0] addr);
    uword_t w;
    unique case (addr)
      UPC_WAIT: w = '{act: ACT_LOAD,   cond: COND_NO_IN,      target: UPC_WAIT};
      UPC_CONV: w = '{act: ACT_DABBLE, cond: COND_CNT_NZ,     target: UPC_CONV};
      UPC_SKIP: w = '{act: ACT_SHIFT,  cond: COND_LEAD_ZERO,  target: UPC_SKIP};
      UPC_EMIT: w = '{act: ACT_EMIT,   cond: COND_EMIT_AGAIN, target: UPC_EMIT};
      default:  w = '{act: ACT_NOP,    cond: COND_ALWAYS,     target: UPC_WAIT};
    endcase
    return w;
  endfunction

  function automatic logic [CharW-1:0] digit_char(logic [DigitW-1:0] d);
    logic [CharW-1:0] dx;
    dx = CharW'(d);
    return (d < 4'd10) ? (CharZero + dx) : (CharLetter + dx);
  endfunction

endpackage

@@ hw/rtl/itrad_sequencer.sv @@
// Microcode sequencer: step counter, control ROM and jump condition logic.
module itrad_sequencer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  itrad_pkg::dp_status_t status_i,
  output itrad_pkg::act_e      act_o
);

  logic [itrad_pkg::UpcW-1:0] upc_q, upc_d;
  itrad_pkg::uword_t          word;
  logic                       take;

  assign word  = itrad_pkg::ucode_rom(upc_q);
  assign act_o = word.act;

  always_comb begin
    unique case (word.cond)
      itrad_pkg::COND_ALWAYS:     take = 1'b1;
      itrad_pkg::COND_NO_IN:      take = !status_i.in_valid;
      itrad_pkg::COND_CNT_NZ:     take = status_i.cnt_nz;
      itrad_pkg::COND_LEAD_ZERO:  take = status_i.lead_zero;
      itrad_pkg::COND_EMIT_AGAIN: take = status_i.out_busy || status_i.idx_nz;
      default:                    take = 1'b1;
    endcase
    upc_d = take ? word.target : upc_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= itrad_pkg::UPC_WAIT;
    end else begin
      upc_q <= upc_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (act_o == itrad_pkg::ACT_LOAD) |-> (upc_q == itrad_pkg::UPC_WAIT))
    else $error("load issued outside the wait step");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upc_q == itrad_pkg::UPC_DONE) |=> (upc_q == itrad_pkg::UPC_WAIT))
    else $error("done step did not return to wait");

endmodule

@@ hw/rtl/itrad_datapath.sv @@
// Datapath: operand shifter, BCD/digit register, counters and output register.
module itrad_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  itrad_pkg::act_e                      act_i,
  input  logic                                 in_valid_i,
  input  logic [1:0]                           op_i,
  input  logic [itrad_pkg::ValueWidth-1:0]     value_i,
  input  logic                                 out_stall_i,
  output itrad_pkg::dp_status_t                status_o,
  output logic                                 out_valid_o,
  output logic [itrad_pkg::CharW-1:0]          digit_char_o,
  output logic                                 last_o
);

  logic [itrad_pkg::NumDigits-1:0][itrad_pkg::DigitW-1:0] dig_q, dig_d, adj, ld_dig;
  logic [itrad_pkg::ValueWidth-1:0] val_q, val_d;
  logic [itrad_pkg::CntW-1:0]       cnt_q, cnt_d;
  logic [itrad_pkg::IdxW-1:0]       idx_q, idx_d;
  logic                             out_valid_q, out_valid_d;
  logic [itrad_pkg::CharW-1:0]      char_q, char_d;
  logic                             last_q, last_d;

  logic [itrad_pkg::DigitW-1:0] top;
  logic [itrad_pkg::OctW-1:0]   oct_src;
  logic [itrad_pkg::DigW-1:0]   hex_src;
  logic [itrad_pkg::DigW:0]     dab_flat;
  logic                         out_free;
  logic                         is_dec;

  assign top      = dig_q[itrad_pkg::NumDigits-1];
  assign oct_src  = itrad_pkg::OctW'(value_i);
  assign hex_src  = itrad_pkg::DigW'(value_i);
  assign out_free = !out_valid_q || !out_stall_i;
  assign is_dec   = (op_i != itrad_pkg::OP_OCT) && (op_i != itrad_pkg::OP_HEX);

  // Parallel digit load for power-of-two radices; add-3 correction for BCD.
  always_comb begin
    for (int k = 0; k < itrad_pkg::NumDigits; k++) begin
      unique case (op_i)
        itrad_pkg::OP_OCT: ld_dig[k] = {1'b0, oct_src[3*k +: 3]};
        itrad_pkg::OP_HEX: ld_dig[k] = hex_src[itrad_pkg::DigitW*k +: itrad_pkg::DigitW];
        default:           ld_dig[k] = '0;
      endcase
      adj[k] = (dig_q[k] >= 4'd5) ? dig_q[k] + 4'd3 : dig_q[k];
    end
  end

  assign dab_flat = {adj, val_q[itrad_pkg::ValueWidth-1]};

  always_comb begin
    dig_d       = dig_q;
    val_d       = val_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && out_stall_i;
    char_d      = char_q;
    last_d      = last_q;
    unique case (act_i)
      itrad_pkg::ACT_LOAD: begin
        if (in_valid_i) begin
          dig_d = ld_dig;
          val_d = value_i;
          cnt_d = is_dec ? itrad_pkg::CntW'(itrad_pkg::ValueWidth) : '0;
          idx_d = itrad_pkg::IdxW'(itrad_pkg::NumDigits - 1);
        end
      end
      itrad_pkg::ACT_DABBLE: begin
        if (cnt_q != '0) begin
          dig_d = dab_flat[itrad_pkg::DigW-1:0];
          val_d = {val_q[itrad_pkg::ValueWidth-2:0], 1'b0};
          cnt_d = cnt_q - 1'b1;
        end
      end
      itrad_pkg::ACT_SHIFT: begin
        if (top == '0 && idx_q != '0) begin
          dig_d = {dig_q[itrad_pkg::NumDigits-2:0], itrad_pkg::DigitW'(0)};
          idx_d = idx_q - 1'b1;
        end
      end
      itrad_pkg::ACT_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          char_d      = itrad_pkg::digit_char(top);
          last_d      = (idx_q == '0);
          dig_d       = {dig_q[itrad_pkg::NumDigits-2:0], itrad_pkg::DigitW'(0)};
          if (idx_q != '0) idx_d = idx_q - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q  <= dig_d;
    val_q  <= val_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign status_o.in_valid  = in_valid_i;
  assign status_o.cnt_nz    = (cnt_q != '0);
  assign status_o.lead_zero = (top == '0) && (idx_q != '0);
  assign status_o.out_busy  = out_valid_q && out_stall_i;
  assign status_o.idx_nz    = (idx_q != '0);

  assign out_valid_o  = out_valid_q;
  assign digit_char_o = char_q;
  assign last_o       = last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((char_q >= 7'h30 && char_q <= 7'h39) ||
                     (char_q >= 7'h61 && char_q <= 7'h66)))
    else $error("emitted character is not a digit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= itrad_pkg::CntW'(itrad_pkg::ValueWidth))
    else $error("dabble counter out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (act_i == itrad_pkg::ACT_DABBLE && cnt_q != '0) |-> (idx_q == itrad_pkg::IdxW'(itrad_pkg::NumDigits - 1)))
    else $error("digit index moved during BCD conversion");

endmodule

@@ hw/rtl/int_to_radix_ascii_digits_top.sv @@
// Top level of the integer to ASCII radix digit converter.
//
//   channel | direction | handshake                  | payload
//   in      | input     | in_valid_i / in_stall_o    | op_i[1:0], value_i[31:0]
//   out     | output    | out_valid_o / out_stall_i  | digit_char_o[6:0], last_o
//
// Decimal conversion runs one shift-add-3 step per operand bit, then a
// counter check; octal and hex digits are loaded at once. The microcode step
// counter runs one item at a time, so the next item is taken only once the
// last digit beat has been loaded. A digit beat other than the final one that
// waits under out_stall_i holds the emit step; a stalled final beat can only
// delay the next item's first digit. Reset returns the step counter to the
// wait step and clears the output valid.
module int_to_radix_ascii_digits_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       op_i,
  input  logic [itrad_pkg::ValueWidth-1:0] value_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [itrad_pkg::CharW-1:0]      digit_char_o,
  output logic                             last_o
);

  itrad_pkg::act_e       act;
  itrad_pkg::dp_status_t status;

  itrad_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .act_o    (act)
  );

  itrad_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .act_i        (act),
    .in_valid_i   (in_valid_i),
    .op_i         (op_i),
    .value_i      (value_i),
    .out_stall_i  (out_stall_i),
    .status_o     (status),
    .out_valid_o  (out_valid_o),
    .digit_char_o (digit_char_o),
    .last_o       (last_o)
  );

  assign in_stall_o = (act != itrad_pkg::ACT_LOAD);

endmodule
